// ----- src/rbdu_pkg.sv -----
// Shared constants and types for the radial-basis distance unit.
package rbdu_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    localparam int SUM_W  = 40;
    localparam int DIST_W = 20;
    localparam int CS_W   = 41;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // coeff_mode codes
    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_ADD  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_SUB  = 3'd3;
    localparam logic [2:0] MODE_RSUB = 3'd4;
    localparam logic [2:0] MODE_CDIV = 3'd5;
    localparam logic [2:0] MODE_XDIV = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // register byte address of coeff_mode
    localparam logic [2:0] ADDR_COEFF_MODE = 3'd0;

    typedef struct packed {
        logic [CS_W-1:0] a;
        logic [CS_W-1:0] b;
    } t_cs_in;

    typedef struct packed {
        logic            ge;
        logic [CS_W-1:0] diff;
    } t_cs_out;

endpackage

// ----- src/radial_basis_distance_unit.sv -----
// Radial-basis neuron: sum of squared differences, coefficient combine, integer root.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata = signal, weight; tlast = last
//  m_axis    out  tvalid/tready              tdata = distance; tuser = status
//  apb       in   psel/penable/pwrite/pready coeff_mode at byte address 0
//
// A pair that is not last passes capture, shared multiplier and accumulate. A last pair
// adds the combine (none: finish; add/sub: absolute value; multiply: high, low, add;
// divide: one quotient bit a cycle via the shared subtractor, none on a zero divisor), 20
// root digits via the same subtractor (skipped on divide by zero or negative) and a load.
// Reset is synchronous, active low; it clears the sum, saturation flag, count, mode, state and output valid.
// A result waits in the output register; a second one holds the sequencer until taken.
module radial_basis_distance_unit import rbdu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] signal, [31:16] weight
    input  logic        s_axis_tlast,   // last
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] distance, [23:20] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_COMB = 4'd3;
    localparam logic [3:0] S_ABS  = 4'd4;
    localparam logic [3:0] S_MULH = 4'd5;
    localparam logic [3:0] S_MULL = 4'd6;
    localparam logic [3:0] S_MADD = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'(DIST_W - 1);

    logic [3:0]        r_state;
    logic [2:0]        r_mode;
    logic [15:0]       r_sig;
    logic [15:0]       r_wgt;
    logic              r_last;
    logic              r_cpair;
    logic [16:0]       r_d;
    logic [SUM_W-1:0]  r_sum;
    logic              r_sat;
    logic [CNT_W-1:0]  r_cnt;
    logic [55:0]       r_prod;
    logic [31:0]       r_c;
    logic signed [41:0] r_x;
    logic [63:0]       r_q;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_dvs;
    logic              r_neg;
    logic              r_dz;
    logic [1:0]        r_stat;
    logic [DIST_W-1:0] r_root;
    logic [5:0]        r_it;
    logic              r_ovalid;
    logic [DIST_W-1:0] r_odist;
    logic [1:0]        r_ostat;

    logic              w_in_acc;
    logic              w_cfg_wr;
    logic              w_out_free;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic [31:0]       w_cneg;
    logic [30:0]       w_cmag;
    logic [SUM_W:0]    w_acc;
    logic signed [41:0] w_sx;
    logic signed [41:0] w_cx;
    logic [41:0]       w_xneg;
    logic [22:0]       w_sq_a;
    logic [21:0]       w_sq_b;
    logic [SUM_W:0]    w_dv_a;
    logic              w_nz;
    logic              w_big;
    t_cs_in            w_cs_in;
    t_cs_out           w_cs_out;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(24 - DIST_W){1'b0}}, r_odist};
    assign m_axis_tuser  = r_ostat;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == ADDR_COEFF_MODE[2]) ? {29'b0, r_mode} : 32'b0;

    assign w_cneg = -r_c;
    assign w_cmag = r_c[31] ? w_cneg[30:0] : r_c[30:0];

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MUL: begin
                if (r_cpair) begin
                    w_ma = {{17{r_wgt[15]}}, r_wgt};
                    w_mb = {{17{r_sig[15]}}, r_sig};
                end else begin
                    w_ma = {{16{r_d[16]}}, r_d};
                    w_mb = {{16{r_d[16]}}, r_d};
                end
            end
            S_MULH: begin
                w_ma = {17'b0, r_sum[39:24]};
                w_mb = {2'b0, w_cmag};
            end
            S_MULL: begin
                w_ma = {9'b0, r_sum[23:0]};
                w_mb = {2'b0, w_cmag};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_acc  = {1'b0, r_sum} + {9'b0, r_prod[31:0]};
    assign w_sx   = {2'b00, r_sum};
    assign w_cx   = {{10{r_c[31]}}, r_c};
    assign w_xneg = -r_x;

    // shared subtractor: division step or root digit
    assign w_dv_a = {r_rem, r_q[63]};
    assign w_sq_a = {r_rem[20:0], r_q[63:62]};
    assign w_sq_b = {r_root, 2'b01};

    always_comb begin
        if (r_state == S_SQRT) begin
            w_cs_in.a = {18'b0, w_sq_a};
            w_cs_in.b = {19'b0, w_sq_b};
        end else begin
            w_cs_in.a = w_dv_a;
            w_cs_in.b = {1'b0, r_dvs};
        end
    end

    rbdu_cmpsub u_cmpsub (
        .i_op  (w_cs_in),
        .o_res (w_cs_out)
    );

    assign w_nz  = |r_q;
    assign w_big = |r_q[63:SUM_W];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (w_cfg_wr && (paddr[2] == ADDR_COEFF_MODE[2])) begin
            r_mode <= pwdata[2:0];
        end
    end

    // sequencer and data path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_sat    <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_sig   <= s_axis_tdata[15:0];
                        r_wgt   <= s_axis_tdata[31:16];
                        r_last  <= s_axis_tlast;
                        r_cpair <= s_axis_tlast && (r_mode >= MODE_ADD)
                                   && (r_mode <= MODE_XDIV);
                        r_d     <= {s_axis_tdata[31], s_axis_tdata[31:16]}
                                   - {s_axis_tdata[15], s_axis_tdata[15:0]};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod[55:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_cpair) begin
                        if (r_cnt >= CNT_W'(MAX_ELEMENTS)) begin
                            // overlong vector: drop the pair
                            r_sat <= 1'b1;
                        end else begin
                            if (w_acc[SUM_W]) begin
                                r_sum <= SUM_MAX;
                                r_sat <= 1'b1;
                            end else begin
                                r_sum <= w_acc[SUM_W-1:0];
                            end
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_c     <= r_cpair ? r_prod[31:0] : 32'b0;
                    r_state <= r_last ? S_COMB : S_IDLE;
                end
                S_COMB: begin
                    r_dz  <= ((r_mode == MODE_CDIV) && (r_sum == '0))
                             || ((r_mode == MODE_XDIV) && (w_cmag == '0));
                    // coefficient is zero outside the coefficient modes
                    r_neg <= r_c[31];
                    r_rem <= '0;
                    r_it  <= '0;
                    case (r_mode)
                        MODE_ADD: begin
                            r_x     <= w_sx + w_cx;
                            r_state <= S_ABS;
                        end
                        MODE_SUB: begin
                            r_x     <= w_sx - w_cx;
                            r_state <= S_ABS;
                        end
                        MODE_RSUB: begin
                            r_x     <= w_cx - w_sx;
                            r_state <= S_ABS;
                        end
                        MODE_MUL: begin
                            r_state <= S_MULH;
                        end
                        MODE_CDIV: begin
                            r_q   <= {9'b0, w_cmag, 24'b0};
                            r_dvs <= r_sum;
                            if (r_sum == '0) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        MODE_XDIV: begin
                            r_q   <= {r_sum, 24'b0};
                            r_dvs <= {9'b0, w_cmag};
                            if (w_cmag == '0) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: begin
                            r_q     <= {24'b0, r_sum};
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_ABS: begin
                    r_neg   <= r_x[41];
                    r_q     <= {22'b0, (r_x[41] ? w_xneg : r_x)};
                    r_state <= S_FIN;
                end
                S_MULH: begin
                    r_prod  <= w_prod[55:0];
                    r_state <= S_MULL;
                end
                S_MULL: begin
                    r_q     <= {16'b0, r_prod[47:0]};
                    r_prod  <= w_prod[55:0];
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    // add the truncated low partial product
                    r_q     <= r_q + {33'b0, r_prod[54:24]};
                    r_state <= S_FIN;
                end
                S_DIV: begin
                    r_rem <= w_cs_out.ge ? w_cs_out.diff[SUM_W-1:0] : w_dv_a[SUM_W-1:0];
                    r_q   <= {r_q[62:0], w_cs_out.ge};
                    r_it  <= r_it + 1'b1;
                    if (r_it == DIV_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_it   <= '0;
                    if (r_dz) begin
                        r_stat  <= ST_DIV0;
                        r_state <= S_DONE;
                    end else if (r_neg && w_nz) begin
                        r_stat  <= ST_NEG;
                        r_state <= S_DONE;
                    end else begin
                        r_stat  <= (w_big || r_sat) ? ST_SAT : ST_OK;
                        r_q     <= {(w_big ? SUM_MAX : r_q[SUM_W-1:0]), 24'b0};
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rem  <= w_cs_out.ge ? {17'b0, w_cs_out.diff[22:0]} : {17'b0, w_sq_a};
                    r_root <= {r_root[DIST_W-2:0], w_cs_out.ge};
                    r_q    <= {r_q[61:0], 2'b00};
                    r_it   <= r_it + 1'b1;
                    if (r_it == SQRT_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register frees up
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odist  <= r_root;
                        r_ostat  <= r_stat;
                        r_sum    <= '0;
                        r_sat    <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/rbdu_cmpsub.sv -----
// Shared compare-and-subtract unit used by the divider and the square root steps.
module rbdu_cmpsub import rbdu_pkg::*; (
    input  t_cs_in  i_op,
    output t_cs_out o_res
);

    logic [CS_W:0] w_full;

    // borrow out of the top bit means a < b
    assign w_full     = {1'b0, i_op.a} - {1'b0, i_op.b};
    assign o_res.ge   = ~w_full[CS_W];
    assign o_res.diff = w_full[CS_W-1:0];

endmodule

// ----- src/rbdu_checker.sv -----
// Port-level checks for the radial-basis distance unit, bound to the top level.
module rbdu_checker import rbdu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // each accepted word keeps the sequencer busy, so input ready drops in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // error status carries a zero distance
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_DIV0 || m_axis_tuser == ST_NEG) |->
            m_axis_tdata == 24'd0)
        else $error("nonzero distance with error status");

    // padding above the distance stays clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:DIST_W] == '0)
        else $error("padding bits set in result word");

endmodule

bind radial_basis_distance_unit rbdu_checker u_rbdu_checker (.*);
